// ===== rtl/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 hash engine.
// Used by md5_round and md5_hash_engine; depends on nothing else.
`default_nettype none

package md5_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_abcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } md5_state_t;

    localparam logic       CMD_ABSORB = 1'b0;
    localparam logic       CMD_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_LANE  = 6'h3f;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    localparam md5_abcd_t MD5_IV = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;
            4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;
            4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;
            4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;
            4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;
            4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;
            4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;
            4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;
            4'b1111: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] w;
        unique case (r[5:4])
            2'd0:    w = r[3:0];
            2'd1:    w = 4'(4'd5 * r[3:0] + 4'd1);
            2'd2:    w = 4'(4'd3 * r[3:0] + 4'd5);
            2'd3:    w = 4'(4'd7 * r[3:0]);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_hash_engine.sv =====
// Steps: an absorbed byte is only accepted; the byte that fills a block is accepted,
// then runs every round through the one round unit, then the chaining add.
// A finish runs the same steps, twice when the padding spills into an extra block,
// then four digest items follow at one per cycle while rsp_ready is high.
// Flow: one item at a time; no new byte is taken until the engine is idle again.
// Reset: chaining words return to the MD5 initial vector, byte count to zero.
`default_nettype none

module md5_hash_engine (
    input  var logic              clk,
    input  var logic              rst_n,
    input  var logic              req_valid,
    output logic                  req_ready,
    input  var md5_pkg::md5_in_t  req,
    output logic                  rsp_valid,
    input  var logic              rsp_ready,
    output md5_pkg::md5_out_t     rsp
);

    md5_pkg::md5_state_t state_reg, state_next;
    md5_pkg::md5_abcd_t  chain_reg, chain_next;
    md5_pkg::md5_abcd_t  work_reg, work_next;
    md5_pkg::md5_abcd_t  round_in, round_out;
    logic [15:0][31:0]   blk_reg, blk_next;
    logic [60:0]         cnt_reg, cnt_next;
    logic [5:0]          rnd_reg, rnd_next;
    logic [1:0]          widx_reg, widx_next;
    logic                fin_reg, fin_next;
    logic                extra_reg, extra_next;
    logic [5:0]          pos;
    logic                req_fire;
    logic                rsp_fire;

    assign pos      = cnt_reg[5:0];
    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;
    assign round_in = (rnd_reg == '0) ? chain_reg : work_reg;

    md5_round u_round (
        .st       (round_in),
        .rnd      (rnd_reg),
        .msg_word (blk_reg[md5_pkg::msg_index(rnd_reg)]),
        .st_out   (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (req_fire && (req.cmd == md5_pkg::CMD_FINISH || pos == md5_pkg::LAST_LANE))
                    state_next = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_ROUND:
            begin
                if (rnd_reg == md5_pkg::LAST_ROUND)
                    state_next = md5_pkg::ST_ADD;
            end
            md5_pkg::ST_ADD:
            begin
                if (extra_reg)
                    state_next = md5_pkg::ST_ROUND;
                else if (fin_reg)
                    state_next = md5_pkg::ST_EMIT;
                else
                    state_next = md5_pkg::ST_IDLE;
            end
            md5_pkg::ST_EMIT:
            begin
                if (rsp_fire && widx_reg == md5_pkg::LAST_WORD)
                    state_next = md5_pkg::ST_IDLE;
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == md5_pkg::ST_IDLE);
        rsp_valid = (state_reg == md5_pkg::ST_EMIT);
    end

    always_comb
    begin
        case (widx_reg)
            2'd0:    rsp.digest_word = chain_reg.a;
            2'd1:    rsp.digest_word = chain_reg.b;
            2'd2:    rsp.digest_word = chain_reg.c;
            default: rsp.digest_word = chain_reg.d;
        endcase
        rsp.word_index = widx_reg;
        rsp.last_word  = (widx_reg == md5_pkg::LAST_WORD);
    end

    always_comb
    begin
        logic [5:0] p;
        blk_next   = blk_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        fin_next   = fin_reg;
        extra_next = extra_reg;
        p          = '0;
        if (req_fire)
        begin
            rnd_next = '0;
            if (req.cmd == md5_pkg::CMD_ABSORB)
            begin
                blk_next[pos[5:2]][8 * pos[1:0] +: 8] = req.data_byte;
                cnt_next = cnt_reg + 61'd1;
                fin_next = 1'b0;
            end
            else
            begin
                for (int i = 0; i < 64; i++)
                begin
                    p = 6'(i);
                    if (p == pos)
                        blk_next[i / 4][8 * (i % 4) +: 8] = md5_pkg::PAD_BYTE;
                    else if (p > pos)
                        blk_next[i / 4][8 * (i % 4) +: 8] = '0;
                end
                fin_next   = 1'b1;
                extra_next = (pos[5:3] == 3'b111);
                if (pos[5:3] != 3'b111)
                begin
                    blk_next[14] = {cnt_reg[28:0], 3'b000};
                    blk_next[15] = cnt_reg[60:29];
                end
            end
        end
        if (state_reg == md5_pkg::ST_ROUND)
        begin
            work_next = round_out;
            rnd_next  = rnd_reg + 6'd1;
        end
        if (state_reg == md5_pkg::ST_ADD)
        begin
            chain_next.a = chain_reg.a + work_reg.a;
            chain_next.b = chain_reg.b + work_reg.b;
            chain_next.c = chain_reg.c + work_reg.c;
            chain_next.d = chain_reg.d + work_reg.d;
            rnd_next     = '0;
            widx_next    = '0;
            if (extra_reg)
            begin
                for (int i = 0; i < 14; i++)
                    blk_next[i] = '0;
                blk_next[14] = {cnt_reg[28:0], 3'b000};
                blk_next[15] = cnt_reg[60:29];
                extra_next   = 1'b0;
            end
        end
        if (rsp_fire)
        begin
            widx_next = widx_reg + 2'd1;
            if (widx_reg == md5_pkg::LAST_WORD)
            begin
                chain_next = md5_pkg::MD5_IV;
                cnt_next   = '0;
                fin_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::ST_IDLE;
            chain_reg <= md5_pkg::MD5_IV;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            fin_reg   <= fin_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("input and output sides active together");

    a_last_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_ROUND && rnd_reg == md5_pkg::LAST_ROUND)
        |=> (state_reg == md5_pkg::ST_ADD))
        else $error("compression did not end after the last round");

    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && rsp.last_word) |=> (req_ready && cnt_reg == '0))
        else $error("engine not restarted after the final digest item");

    a_extra_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> fin_reg)
        else $error("extra padding block pending outside a finish");

endmodule

`default_nettype wire

// ===== rtl/md5_round.sv =====
// One MD5 round step, shared by all 64 rounds of a compression.
// Depends on md5_pkg for the round tables and the state word struct.
`default_nettype none

module md5_round (
    input  var md5_pkg::md5_abcd_t st,
    input  var logic [5:0]         rnd,
    input  var logic [31:0]        msg_word,
    output md5_pkg::md5_abcd_t     st_out
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  shamt;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = st.d ^ (st.b & (st.c ^ st.d));
            2'd1:    f = st.c ^ (st.d & (st.b ^ st.c));
            2'd2:    f = st.b ^ st.c ^ st.d;
            default: f = st.c ^ (st.b | ~st.d);
        endcase
    end

    assign sum   = st.a + f + msg_word + md5_pkg::round_const(rnd);
    assign shamt = md5_pkg::rot_amt(rnd);
    assign dbl   = {sum, sum} << shamt;

    always_comb
    begin
        st_out.a = st.d;
        st_out.d = st.c;
        st_out.c = st.b;
        st_out.b = st.b + dbl[63:32];
    end

endmodule

`default_nettype wire
